@@ src/pa_pkg.sv @@
package pa_pkg;

	// Input item opcodes
	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_VERTEX = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	// Primitive kinds selected by a begin item
	localparam logic [1:0] KIND_POINTS = 2'd0;
	localparam logic [1:0] KIND_LIST   = 2'd1;
	localparam logic [1:0] KIND_STRIP  = 2'd2;
	localparam logic [1:0] KIND_FAN    = 2'd3;

	// Result kinds
	localparam logic [1:0] OUT_POINT = 2'd0;
	localparam logic [1:0] OUT_TRI   = 2'd1;
	localparam logic [1:0] OUT_LINE  = 2'd2;

	// Draw modes
	localparam logic [1:0] DRAW_SOLID = 2'd0;
	localparam logic [1:0] DRAW_WIRE  = 2'd1;

	// Configuration register indexes
	localparam logic [1:0] CFG_EMIT_FRONT  = 2'd0;
	localparam logic [1:0] CFG_EMIT_BACK   = 2'd1;
	localparam logic [1:0] CFG_DRAW_MODE   = 2'd2;
	localparam logic [1:0] CFG_TILE_ENABLE = 2'd3;

	// Default index width, vertex reference width and job queue depth
	localparam int INDEX_BITS_DEF = 16;
	localparam int VREF_W         = 16;
	localparam int QUEUE_DEPTH    = 4;

	// Emission steps of one triangle
	localparam logic [2:0] STEP_FIRST     = 3'd0;
	localparam logic [2:0] STEP_FRONT_END = 3'd2;
	localparam logic [2:0] STEP_BACK_BEG  = 3'd3;
	localparam logic [2:0] STEP_LAST      = 3'd5;

	typedef struct packed {
		logic       emit_front;
		logic       emit_back;
		logic [1:0] draw_mode;
		logic       tile_enable;
	} cfg_t;

	// Control part of one queued job
	typedef struct packed {
		logic is_point;
		logic sec;
	} job_ctrl_t;

	localparam int JOB_CTRL_W = $bits(job_ctrl_t);

endpackage

@@ src/pa_front.sv @@
module pa_front import pa_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_op,
	input  logic [1:0]            in_kind,
	input  logic [15:0]           in_vidx,
	output logic                  job_valid,
	input  logic                  job_ready,
	output job_ctrl_t             job_ctrl,
	output logic [INDEX_BITS-1:0] job_a,
	output logic [INDEX_BITS-1:0] job_b,
	output logic [INDEX_BITS-1:0] job_c
);

	logic [1:0]            kind_q;
	logic [INDEX_BITS-1:0] first_q, older_q, newer_q;
	logic [1:0]            bpos_q;
	logic [1:0]            seen_q;
	logic [1:0]            lphase_q;
	logic                  lpar_q;
	logic                  tphase_q;

	logic                  accept;
	logic                  is_vertex;
	logic [INDEX_BITS-1:0] v;
	logic                  tri_done;
	logic                  parity;
	logic                  tri_emits;
	logic                  produce;

	assign in_ready  = job_ready;
	assign accept    = in_valid && in_ready;
	assign is_vertex = (in_op == OP_VERTEX);
	assign v         = INDEX_BITS'(in_vidx);

	// Classify the vertex: does it complete a primitive, and with which corners
	always_comb begin
		tri_done = 1'b0;
		parity   = 1'b0;
		job_a    = v;
		job_b    = v;
		job_c    = v;
		case (kind_q) inside
			KIND_POINTS: begin
				job_a = v;
			end
			KIND_LIST: begin
				tri_done = (lphase_q == 2'd2);
				parity   = lpar_q;
				job_a    = older_q;
				job_b    = newer_q;
			end
			KIND_STRIP: begin
				tri_done = (seen_q == 2'd2);
				parity   = ~bpos_q[1];
				if (!bpos_q[0]) begin
					job_a = newer_q;
					job_b = older_q;
				end else begin
					job_a = older_q;
					job_b = newer_q;
				end
			end
			default: begin
				tri_done = (seen_q == 2'd2);
				parity   = ~bpos_q[0];
				job_a    = first_q;
				job_b    = newer_q;
			end
		endcase
	end

	assign tri_emits = (cfg.draw_mode == DRAW_WIRE) ||
		((cfg.draw_mode == DRAW_SOLID) && (cfg.emit_front || cfg.emit_back));

	assign produce = is_vertex && ((kind_q == KIND_POINTS) || (tri_done && tri_emits));

	assign job_valid         = in_valid && produce;
	assign job_ctrl.is_point = (kind_q == KIND_POINTS);
	assign job_ctrl.sec      = cfg.tile_enable && (parity == tphase_q);

	// Advance batch state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_POINTS;
			bpos_q   <= '0;
			seen_q   <= '0;
			lphase_q <= '0;
			lpar_q   <= 1'b0;
			tphase_q <= 1'b0;
		end else if (accept) begin
			unique case (in_op) inside
				OP_BEGIN: begin
					kind_q   <= in_kind;
					tphase_q <= ~tphase_q;
					bpos_q   <= '0;
					seen_q   <= '0;
					lphase_q <= '0;
					lpar_q   <= 1'b0;
				end
				OP_END: begin
					bpos_q   <= '0;
					seen_q   <= '0;
					lphase_q <= '0;
					lpar_q   <= 1'b0;
				end
				OP_VERTEX: begin
					if (kind_q == KIND_LIST) begin
						if (lphase_q == 2'd2) begin
							lphase_q <= '0;
							lpar_q   <= ~lpar_q;
						end else begin
							lphase_q <= lphase_q + 2'd1;
						end
					end else if (kind_q != KIND_POINTS) begin
						bpos_q <= bpos_q + 2'd1;
						if (seen_q != 2'd2)
							seen_q <= seen_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold the vertex history
	always_ff @(posedge clk) begin
		if (accept && is_vertex) begin
			if (kind_q == KIND_LIST) begin
				if (lphase_q == 2'd0)
					older_q <= v;
				else if (lphase_q == 2'd1)
					newer_q <= v;
			end else if (kind_q != KIND_POINTS) begin
				if (seen_q == 2'd0)
					first_q <= v;
				older_q <= newer_q;
				newer_q <= v;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("vertex count went past saturation");
	a_list_phase: assert property (@(posedge clk) disable iff (!arst_n)
		lphase_q != 2'd3)
		else $error("list phase out of range");
`endif

endmodule

@@ src/pa_queue.sv @@
module pa_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	// Store the item
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue occupancy out of range");
`endif

endmodule

@@ src/pa_back.sv @@
module pa_back import pa_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  job_ctrl_t             job_ctrl,
	input  logic [INDEX_BITS-1:0] job_a,
	input  logic [INDEX_BITS-1:0] job_b,
	input  logic [INDEX_BITS-1:0] job_c,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VREF_W-1:0]     out_vref,
	output logic [1:0]            out_kind,
	output logic                  out_neg,
	output logic                  out_sec,
	output logic                  out_last
);

	logic                  busy_q;
	logic [2:0]            step_q;
	job_ctrl_t             ctrl_q;
	logic [INDEX_BITS-1:0] a_q, b_q, c_q;
	logic                  valid_q;

	logic                  slot_free;
	logic                  emit;
	logic                  wire_mode;
	logic                  final_step;
	logic                  load;
	logic [2:0]            start_step;
	logic [INDEX_BITS-1:0] r_ref;
	logic [1:0]            r_kind;
	logic                  r_neg;
	logic                  r_sec;

	assign slot_free = !valid_q || out_ready;
	assign emit      = busy_q && slot_free;
	assign wire_mode = (cfg.draw_mode == DRAW_WIRE);

	always_comb begin
		if (ctrl_q.is_point)
			final_step = 1'b1;
		else if (wire_mode || cfg.emit_back)
			final_step = (step_q == STEP_LAST);
		else
			final_step = (step_q == STEP_FRONT_END);
	end

	assign load      = job_valid && (!busy_q || (emit && final_step));
	assign job_ready = load;

	assign start_step = (!job_ctrl.is_point && !wire_mode && !cfg.emit_front) ?
		STEP_BACK_BEG : STEP_FIRST;

	// Select the result for the current step
	always_comb begin
		r_ref  = a_q;
		r_kind = OUT_POINT;
		r_neg  = 1'b0;
		r_sec  = 1'b0;
		if (!ctrl_q.is_point) begin
			if (wire_mode) begin
				r_kind = OUT_LINE;
				case (step_q) inside
					3'd1, 3'd2: r_ref = b_q;
					3'd3, 3'd4: r_ref = c_q;
					default:    r_ref = a_q;
				endcase
			end else begin
				r_kind = OUT_TRI;
				r_sec  = ctrl_q.sec;
				r_neg  = (step_q >= STEP_BACK_BEG);
				case (step_q) inside
					3'd1, 3'd5: r_ref = b_q;
					3'd2, 3'd4: r_ref = c_q;
					default:    r_ref = a_q;
				endcase
			end
		end
	end

	// Step through the job and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= STEP_FIRST;
			valid_q <= 1'b0;
		end else begin
			if (slot_free)
				valid_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
				step_q <= start_step;
			end else if (emit) begin
				if (final_step)
					busy_q <= 1'b0;
				else
					step_q <= step_q + 3'd1;
			end
		end
	end

	// Capture job and result payload
	always_ff @(posedge clk) begin
		if (load) begin
			ctrl_q <= job_ctrl;
			a_q    <= job_a;
			b_q    <= job_b;
			c_q    <= job_c;
		end
		if (emit) begin
			out_vref <= VREF_W'(r_ref);
			out_kind <= r_kind;
			out_neg  <= r_neg;
			out_sec  <= r_sec;
			out_last <= final_step;
		end
	end

	assign out_valid = valid_q;

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_LAST)
		else $error("emission step out of range");
	a_point_single: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ctrl_q.is_point) |-> step_q == STEP_FIRST)
		else $error("point job advanced past its single result");
`endif

endmodule

@@ src/primitive_assembler.sv @@
// Primitive assembler on vertex indices.
// Path: an accepted item's job is written into the job queue, loaded into the emitter,
// and its first result is registered in the output register. Throughput: while the
// receiver is ready, the emitter gives one result per cycle (1 per point, 3 per solid
// face, 6 per wireframe triangle); items enter every cycle while the job queue has room.
// Reset: arst_n clears batch state, queue, emitter and configuration at once.
module primitive_assembler import pa_pkg::*; #(
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // vertex_index
	input  logic [3:0]  s_axis_tuser,  // opcode[1:0], prim_kind[3:2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // vertex_ref
	output logic [3:0]  m_axis_tuser,  // out_kind[1:0], negate_normal[2], second_color[3]
	output logic        m_axis_tlast
);

	localparam int JOB_W = JOB_CTRL_W + 3 * INDEX_BITS;

	cfg_t                  cfg_q;
	logic                  fq_valid, fq_ready, qb_valid, qb_ready;
	job_ctrl_t             f_ctrl, b_ctrl;
	logic [INDEX_BITS-1:0] f_a, f_b, f_c, b_a, b_b, b_c;
	logic [JOB_W-1:0]      q_in, q_out;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.emit_front  <= 1'b1;
			cfg_q.emit_back   <= 1'b0;
			cfg_q.draw_mode   <= DRAW_SOLID;
			cfg_q.tile_enable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_EMIT_FRONT:  cfg_q.emit_front  <= cfg_wdata[0];
				CFG_EMIT_BACK:   cfg_q.emit_back   <= cfg_wdata[0];
				CFG_DRAW_MODE:   cfg_q.draw_mode   <= cfg_wdata;
				CFG_TILE_ENABLE: cfg_q.tile_enable <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	pa_front #(.INDEX_BITS(INDEX_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser[1:0]),
		.in_kind   (s_axis_tuser[3:2]),
		.in_vidx   (s_axis_tdata),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job_ctrl  (f_ctrl),
		.job_a     (f_a),
		.job_b     (f_b),
		.job_c     (f_c)
	);

	assign q_in = {f_ctrl, f_a, f_b, f_c};

	pa_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (q_in),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (q_out)
	);

	assign {b_ctrl, b_a, b_b, b_c} = q_out;

	pa_back #(.INDEX_BITS(INDEX_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job_ctrl  (b_ctrl),
		.job_a     (b_a),
		.job_b     (b_b),
		.job_c     (b_c),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_vref  (m_axis_tdata),
		.out_kind  (m_axis_tuser[1:0]),
		.out_neg   (m_axis_tuser[2]),
		.out_sec   (m_axis_tuser[3]),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ tb/primitive_assembler_tb.sv @@
`timescale 1ns / 100ps

module primitive_assembler_tb;
	import pa_pkg::*;

	// Opcode that the block must ignore, and the draw modes that emit no triangles
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] DRAW_OFF    = 2'd2;
	localparam logic [1:0] DRAW_OFF_HI = 2'd3;
	localparam int         N_DIRECTED  = 25;
	localparam int         N_SETTINGS  = 7;
	localparam int         LONG_HOLD   = 80;

	typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_POINT} row_check_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  kind;
		logic [15:0] vidx;
		row_check_t  chk;
	} stim_row_t;

	typedef struct packed {
		logic [15:0] vref;
		logic [1:0]  kind;
		logic        neg;
		logic        sec;
		logic        last;
	} vtx_out_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [1:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // vertex_index
	logic [3:0]  s_axis_tuser;   // opcode[1:0], prim_kind[3:2]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // vertex_ref
	logic [3:0]  m_axis_tuser;   // out_kind[1:0], negate_normal[2], second_color[3]
	logic        m_axis_tlast;

	// Predictor copy of the registers and the batch state
	cfg_t        cfg;
	logic [1:0]  sel_kind;
	logic [15:0] fan_root;
	logic [15:0] prev2_vtx;
	logic [15:0] prev1_vtx;
	logic [1:0]  strip_pos;
	logic [1:0]  strip_fill;
	logic [1:0]  list_fill;
	logic        list_odd;
	logic        tile_toggle;

	vtx_out_t    item_refs[$];
	vtx_out_t    pending_refs[$];
	vtx_out_t    got_ref;
	vtx_out_t    want_ref;

	stim_row_t   dir_rows [N_DIRECTED];
	cfg_t        cfg_plan [N_SETTINGS];

	int          mismatches;
	int          items_sent;
	int          refs_checked;
	bit          tx_idle_on;
	bit          rx_idle_on;
	bit          rx_hold_req;
	int          rx_stall_left;

	primitive_assembler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run in case the block hangs
	initial begin
		#4_000_000;
		$display("%0t: timeout, %0d vertex references still expected", $time,
			pending_refs.size());
		$display("primitive_assembler_tb NOT OK");
		$finish;
	end

	function automatic void add_ref(input logic [15:0] v, input logic [1:0] kind,
			input logic neg, input logic sec);
		vtx_out_t r;
		r.vref = v;
		r.kind = kind;
		r.neg  = neg;
		r.sec  = sec;
		r.last = 1'b0;
		item_refs = {item_refs, r};
	endfunction

	// Expand one triangle into face vertices or edge endpoints
	function automatic void emit_triangle(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c, input logic parity);
		logic sec;
		sec = cfg.tile_enable && (parity == tile_toggle);
		if (cfg.draw_mode == DRAW_SOLID) begin
			if (cfg.emit_front) begin
				add_ref(a, OUT_TRI, 1'b0, sec);
				add_ref(b, OUT_TRI, 1'b0, sec);
				add_ref(c, OUT_TRI, 1'b0, sec);
			end
			if (cfg.emit_back) begin
				add_ref(a, OUT_TRI, 1'b1, sec);
				add_ref(c, OUT_TRI, 1'b1, sec);
				add_ref(b, OUT_TRI, 1'b1, sec);
			end
		end else if (cfg.draw_mode == DRAW_WIRE) begin
			add_ref(a, OUT_LINE, 1'b0, 1'b0);
			add_ref(b, OUT_LINE, 1'b0, 1'b0);
			add_ref(b, OUT_LINE, 1'b0, 1'b0);
			add_ref(c, OUT_LINE, 1'b0, 1'b0);
			add_ref(c, OUT_LINE, 1'b0, 1'b0);
			add_ref(a, OUT_LINE, 1'b0, 1'b0);
		end
	endfunction

	function automatic void clear_batch();
		strip_pos  = 2'd0;
		strip_fill = 2'd0;
		list_fill  = 2'd0;
		list_odd   = 1'b0;
	endfunction

	// Advance the batch state by one item and collect its vertex references
	function automatic void assemble_item(input logic [1:0] op, input logic [1:0] kind,
			input logic [15:0] v);
		logic [1:0] k;
		logic [1:0] k2;
		vtx_out_t   tail;
		item_refs.delete();
		if (op == OP_BEGIN) begin
			sel_kind    = kind;
			tile_toggle = ~tile_toggle;
			clear_batch();
		end else if (op == OP_END) begin
			clear_batch();
		end else if (op == OP_VERTEX) begin
			if (sel_kind == KIND_POINTS) begin
				add_ref(v, OUT_POINT, 1'b0, 1'b0);
			end else if (sel_kind == KIND_LIST) begin
				if (list_fill == 2'd0) begin
					prev2_vtx = v;
					list_fill = 2'd1;
				end else if (list_fill == 2'd1) begin
					prev1_vtx = v;
					list_fill = 2'd2;
				end else begin
					emit_triangle(prev2_vtx, prev1_vtx, v, list_odd);
					list_odd  = ~list_odd;
					list_fill = 2'd0;
				end
			end else begin
				k  = strip_pos;
				k2 = k + 2'd2;
				if (strip_fill == 2'd2) begin
					if (sel_kind == KIND_STRIP) begin
						// alternate winding so every strip triangle keeps its facing
						if (!k[0])
							emit_triangle(prev1_vtx, prev2_vtx, v, k2[1]);
						else
							emit_triangle(prev2_vtx, prev1_vtx, v, k2[1]);
					end else begin
						emit_triangle(fan_root, prev1_vtx, v, ~k[0]);
					end
				end
				if (strip_fill == 2'd0)
					fan_root = v;
				prev2_vtx = prev1_vtx;
				prev1_vtx = v;
				strip_pos = k + 2'd1;
				if (strip_fill != 2'd2)
					strip_fill = strip_fill + 2'd1;
			end
		end
		// mark the final reference of the item
		if (item_refs.size() > 0) begin
			tail = item_refs.pop_back();
			tail.last = 1'b1;
			item_refs = {item_refs, tail};
		end
	endfunction

	// Offer one item, hold it until accepted, then queue what it should produce
	task automatic send_item(input logic [1:0] op, input logic [1:0] kind,
			input logic [15:0] v, input row_check_t chk);
		vtx_out_t pt;
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {kind, op};
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		assemble_item(op, kind, v);
		case (chk)
			CHK_PRED: begin
				pending_refs = {pending_refs, item_refs};
			end
			CHK_POINT: begin
				pt.vref = v;
				pt.kind = OUT_POINT;
				pt.neg  = 1'b0;
				pt.sec  = 1'b0;
				pt.last = 1'b1;
				pending_refs = {pending_refs, pt};
			end
			default: ;
		endcase
		if (op != OP_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_index();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random batches: mostly begin, vertices, end; some noise and cut-off batches
	task automatic run_batches(input int n_items);
		int         stop_at;
		int         nv;
		logic [1:0] kind;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			kind = 2'($urandom);
			if ($urandom_range(0, 9) != 0)
				send_item(OP_BEGIN, kind, 16'($urandom), CHK_PRED);
			if (kind == KIND_LIST)
				nv = 3 * $urandom_range(0, 3) + (($urandom_range(0, 3) == 0) ?
					$urandom_range(1, 2) : 0);
			else
				nv = $urandom_range(0, 8);
			for (int i = 0; i < nv; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(OP_UNUSED, 2'($urandom), pick_index(), CHK_PRED);
				send_item(OP_VERTEX, 2'($urandom), pick_index(), CHK_PRED);
			end
			if ($urandom_range(0, 3) != 0)
				send_item(OP_END, 2'($urandom), 16'($urandom), CHK_PRED);
		end
	endtask

	// Pause the sender until every expected reference is out, then let the block settle
	task automatic drain_and_wait(input int tail_cycles);
		s_axis_tvalid <= 1'b0;
		while (pending_refs.size() != 0) @(negedge clk);
		repeat (tail_cycles) @(negedge clk);
	endtask

	task automatic write_cfg(input cfg_t c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_EMIT_FRONT;
		cfg_wdata <= {1'b0, c.emit_front};
		@(negedge clk);
		cfg_index <= CFG_EMIT_BACK;
		cfg_wdata <= {1'b0, c.emit_back};
		@(negedge clk);
		cfg_index <= CFG_DRAW_MODE;
		cfg_wdata <= c.draw_mode;
		@(negedge clk);
		cfg_index <= CFG_TILE_ENABLE;
		cfg_wdata <= {1'b0, c.tile_enable};
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg = c;
	endtask

	// Receiver: random stall bursts, plus one long hold on request
	initial begin
		m_axis_tready = 1'b0;
		rx_stall_left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req   = 1'b0;
				rx_stall_left = LONG_HOLD;
			end
			if (rx_stall_left > 0) begin
				m_axis_tready <= 1'b0;
				rx_stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				rx_stall_left = $urandom_range(0, 8);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Check every accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_ref.vref = m_axis_tdata;
			got_ref.kind = m_axis_tuser[1:0];
			got_ref.neg  = m_axis_tuser[2];
			got_ref.sec  = m_axis_tuser[3];
			got_ref.last = m_axis_tlast;
			if (pending_refs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result ref=%h kind=%0d neg=%b sec=%b last=%b",
					$time, got_ref.vref, got_ref.kind, got_ref.neg, got_ref.sec,
					got_ref.last);
			end else begin
				want_ref = pending_refs.pop_front();
				refs_checked++;
				if (got_ref !== want_ref) begin
					mismatches++;
					$display({"%0t: mismatch expected ref=%h kind=%0d neg=%b sec=%b last=%b,",
						" got ref=%h kind=%0d neg=%b sec=%b last=%b"}, $time,
						want_ref.vref, want_ref.kind, want_ref.neg, want_ref.sec,
						want_ref.last, got_ref.vref, got_ref.kind, got_ref.neg,
						got_ref.sec, got_ref.last);
				end
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_EMIT_FRONT;
		cfg_wdata     = 2'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'd0;
		s_axis_tuser  = {KIND_POINTS, OP_BEGIN};
		mismatches    = 0;
		items_sent    = 0;
		refs_checked  = 0;
		tx_idle_on    = 1'b1;
		rx_idle_on    = 1'b1;
		rx_hold_req   = 1'b0;

		// Predictor state after reset
		cfg.emit_front   = 1'b1;
		cfg.emit_back    = 1'b0;
		cfg.draw_mode    = DRAW_SOLID;
		cfg.tile_enable  = 1'b0;
		sel_kind    = KIND_POINTS;
		fan_root    = 16'd0;
		prev2_vtx   = 16'd0;
		prev1_vtx   = 16'd0;
		tile_toggle = 1'b0;
		clear_batch();

		// Directed items under the reset settings (front faces, solid, no tiling)
		dir_rows = '{
			'{OP_VERTEX, KIND_POINTS, 16'h0000, CHK_POINT}, // points without a begin
			'{OP_VERTEX, KIND_FAN,    16'hffff, CHK_POINT},
			'{OP_UNUSED, KIND_FAN,    16'hffff, CHK_NONE},  // ignored opcode
			'{OP_BEGIN,  KIND_LIST,   16'h0000, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0001, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0002, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0003, CHK_PRED},
			'{OP_VERTEX, KIND_POINTS, 16'h1234, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'hffff, CHK_NONE},
			'{OP_END,    KIND_FAN,    16'hffff, CHK_NONE},  // drop the partial triangle
			'{OP_VERTEX, KIND_POINTS, 16'h0005, CHK_NONE},  // list again, fresh batch
			'{OP_BEGIN,  KIND_STRIP,  16'hffff, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0010, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0011, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0012, CHK_PRED},
			'{OP_VERTEX, KIND_POINTS, 16'h0013, CHK_PRED},
			'{OP_VERTEX, KIND_POINTS, 16'h0014, CHK_PRED},
			'{OP_END,    KIND_POINTS, 16'h0000, CHK_NONE},
			'{OP_BEGIN,  KIND_FAN,    16'h0000, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h8000, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h7fff, CHK_NONE},
			'{OP_VERTEX, KIND_POINTS, 16'h0001, CHK_PRED},
			'{OP_VERTEX, KIND_POINTS, 16'hfffe, CHK_PRED},
			'{OP_BEGIN,  KIND_POINTS, 16'h5a5a, CHK_NONE},
			'{OP_VERTEX, KIND_STRIP,  16'ha5a5, CHK_POINT}
		};

		// Register settings for the random phases; the last one runs without idling
		cfg_plan = '{
			'{1'b1, 1'b1, DRAW_SOLID,  1'b1},
			'{1'b0, 1'b0, DRAW_SOLID,  1'b1},
			'{1'b0, 1'b1, DRAW_SOLID,  1'b0},
			'{1'b1, 1'b1, DRAW_WIRE,   1'b1},
			'{1'b1, 1'b0, DRAW_OFF,    1'b1},
			'{1'b0, 1'b1, DRAW_OFF_HI, 1'b0},
			'{1'b1, 1'b0, DRAW_SOLID,  1'b1}
		};

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].kind, dir_rows[i].vidx, dir_rows[i].chk);
		drain_and_wait(8);

		for (int p = 0; p < N_SETTINGS; p++) begin
			write_cfg(cfg_plan[p]);
			// first phase: no sender gaps while the receiver holds off, so the block backs up
			tx_idle_on = (p != 0) && (p != N_SETTINGS - 1);
			rx_idle_on = (p != N_SETTINGS - 1);
			if (p == 0)
				rx_hold_req = 1'b1;
			run_batches(27);
			drain_and_wait((p == N_SETTINGS - 1) ? 20 : 8);
		end

		$display("Sent %0d items over %0d register settings plus the reset setting,",
			items_sent, N_SETTINGS);
		$display("checked %0d vertex references; %0d mismatches.", refs_checked, mismatches);
		if (mismatches == 0 && pending_refs.size() == 0)
			$display("primitive_assembler_tb OK");
		else
			$display("primitive_assembler_tb NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
src/pa_pkg.sv
src/pa_front.sv
src/pa_queue.sv
src/pa_back.sv
src/primitive_assembler.sv
tb/primitive_assembler_tb.sv
